FILE: design/msbf_pkg.sv
// ----------------------------------------------------------------------------
// msbf_pkg
// Shared types and constants of the media segment boundary finder.
// ----------------------------------------------------------------------------
`default_nettype none

package msbf_pkg;

  // fixed field widths
  localparam int unsigned MsW   = 45;
  localparam int unsigned TimeW = 64;
  localparam int unsigned CntW  = 32;

  // opcodes of an input item
  localparam logic [1:0] OP_LOAD_RUN  = 2'd0;
  localparam logic [1:0] OP_LOAD_SYNC = 2'd1;
  localparam logic [1:0] OP_COMPUTE   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_START_MS = 2'd0;
  localparam logic [1:0] REG_SEG_SECS = 2'd1;
  localparam logic [1:0] REG_TIMESCALE = 2'd2;
  localparam logic [1:0] REG_MIN_TAIL = 2'd3;

  localparam logic [TimeW-1:0] MS_PER_S = 64'd1000;
  localparam logic [TimeW-1:0] ALL64    = {TimeW{1'b1}};
  localparam logic [MsW-1:0]   MAX45    = {MsW{1'b1}};

  // controller states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RUN_CHK,
    ST_RUN_MUL,
    ST_SY_RD,
    ST_SY_CHK,
    ST_SY_MULW,
    ST_SY_STORE,
    ST_CP_DUR,
    ST_CP_DURW,
    ST_CP_TGTM,
    ST_CP_TGTD,
    ST_SS_RD,
    ST_SS_CHK,
    ST_G_RD,
    ST_G_CHK,
    ST_G_DIVW,
    ST_G_MULW,
    ST_S_END,
    ST_NB_DIV,
    ST_NB_MULW,
    ST_TAIL,
    ST_MS_MUL,
    ST_MS_MULW,
    ST_MS_DIVW,
    ST_FIN
  } state_e;

  // datapath actions
  typedef enum logic [4:0] {
    A_NONE,
    A_ACCEPT,
    A_RUN_WRITE,
    A_RUN_DROP,
    A_RUN_ADD,
    A_SY_NEXT,
    A_SY_MUL,
    A_SY_SUM,
    A_SY_WRITE,
    A_SY_DROP,
    A_DUR_MUL,
    A_DUR_SET,
    A_TGT_DIV,
    A_TGT_SET,
    A_SS_CHK,
    A_G_PREV,
    A_G_DIV,
    A_G_BASE,
    A_G_MUL,
    A_G_SUM,
    A_G_END_TOT,
    A_SRCH_FIRST,
    A_NB_MUL,
    A_NB_SET,
    A_SRCH_SECOND,
    A_TAIL,
    A_MS_MUL,
    A_MS_DIV,
    A_MS_SET,
    A_FIN
  } act_e;

  typedef struct packed {
    act_e act;
    logic in_ready;
  } cmd_t;

  typedef struct packed {
    logic       in_valid;
    logic [1:0] in_op;
    logic       samp_zero;
    logic       run_full;
    logic       sync_full;
    logic       idx_at_rh;
    logic       idx_at_sh;
    logic       idx_zero;
    logic       end_ge_ss;
    logic       grid_skip;
    logic       grid_hit;
    logic       t_gt_st;
    logic       found;
    logic       use_sync;
    logic       ph;
    logic       mul_done;
    logic       div_done;
    logic       out_busy;
  } status_t;

endpackage

`default_nettype wire

FILE: design/msbf_mul.sv
// ----------------------------------------------------------------------------
// msbf_mul
// 64x64 multiplier built from four 32x32 partial products over cycles.
// ----------------------------------------------------------------------------
`default_nettype none

module msbf_mul (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [63:0]   a_i,
  input  wire logic [63:0]   b_i,
  output logic               done_o,
  output logic [127:0]       prod_o
);

  logic [63:0]  a_q, b_q;
  logic [63:0]  pp_q;
  logic [1:0]   sft_q;
  logic [2:0]   cnt_q;
  logic         busy_q, done_q;
  logic [127:0] acc_q;
  logic [31:0]  x, y;
  logic [1:0]   sft;

  // partial product selection
  always_comb begin
    x   = a_q[31:0];
    y   = b_q[31:0];
    sft = 2'd0;
    case (cnt_q)
      3'd0: begin x = a_q[31:0];  y = b_q[31:0];  sft = 2'd0; end
      3'd1: begin x = a_q[31:0];  y = b_q[63:32]; sft = 2'd1; end
      3'd2: begin x = a_q[63:32]; y = b_q[31:0];  sft = 2'd1; end
      3'd3: begin x = a_q[63:32]; y = b_q[63:32]; sft = 2'd2; end
      default: begin x = 32'd0; y = 32'd0; sft = 2'd0; end
    endcase
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 3'd1;
      if (cnt_q == 3'd4) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // operands and accumulation
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= 128'd0;
    end else if (busy_q) begin
      pp_q  <= 64'(x) * 64'(y);
      sft_q <= sft;
      if (cnt_q != 3'd0) begin
        acc_q <= acc_q + ({64'd0, pp_q} << {sft_q, 5'd0});
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

FILE: design/msbf_div.sv
// ----------------------------------------------------------------------------
// msbf_div
// Restoring divider of a 128-bit dividend by a 64-bit divisor, one bit a
// cycle; saturates to all ones when the quotient does not fit 64 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module msbf_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] hi_i,
  input  wire logic [63:0] lo_i,
  input  wire logic [63:0] den_i,
  output logic             done_o,
  output logic [63:0]      quot_o
);

  logic [63:0] rem_q, lo_q, den_q, quot_q;
  logic [6:0]  cnt_q;
  logic        busy_q, done_q;
  logic [63:0] rem_sh;
  logic        carry, take;

  // one restoring step
  always_comb begin
    rem_sh = {rem_q[62:0], lo_q[63]};
    carry  = rem_q[63];
    take   = carry || (rem_sh >= den_q);
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 7'd0;
    end else if (start_i) begin
      busy_q <= (hi_i < den_i);
      done_q <= (hi_i >= den_i);
      cnt_q  <= 7'd64;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= hi_i;
      lo_q   <= lo_i;
      den_q  <= den_i;
      quot_q <= (hi_i >= den_i) ? {64{1'b1}} : 64'd0;
    end else if (busy_q) begin
      rem_q  <= take ? (rem_sh - den_q) : rem_sh;
      lo_q   <= {lo_q[62:0], 1'b0};
      quot_q <= {quot_q[62:0], take};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

FILE: design/msbf_dp.sv
// ----------------------------------------------------------------------------
// msbf_dp
// Datapath: configuration, run and sync tables, totals, search registers,
// shared multiplier and divider, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module msbf_dp #(
  parameter int unsigned RUN_ENTRIES  = 256,
  parameter int unsigned SYNC_ENTRIES = 256
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire msbf_pkg::cmd_t        cmd_i,
  output msbf_pkg::status_t          status_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [1:0]            cfg_addr_i,
  input  wire logic [39:0]           cfg_wdata_i,
  input  wire logic                  in_valid_i,
  input  wire logic [1:0]            in_op_i,
  input  wire logic [95:0]           in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [95:0]                out_data_o,
  output logic [2:0]                 out_user_o
);

  localparam int unsigned RAW = (RUN_ENTRIES > 1) ? $clog2(RUN_ENTRIES) : 1;
  localparam int unsigned SAW = (SYNC_ENTRIES > 1) ? $clog2(SYNC_ENTRIES) : 1;
  localparam int unsigned RCW = $clog2(RUN_ENTRIES + 1);
  localparam int unsigned SCW = $clog2(SYNC_ENTRIES + 1);
  localparam int unsigned IW  = (RCW > SCW) ? RCW : SCW;

  // configuration registers
  logic [39:0] start_ms_q;
  logic [31:0] seg_secs_q, tscale_q;
  logic [7:0]  min_tail_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_ms_q <= 40'd0;
      seg_secs_q <= 32'd10;
      tscale_q   <= 32'd1000;
      min_tail_q <= 8'd1;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        msbf_pkg::REG_START_MS:  start_ms_q <= cfg_wdata_i;
        msbf_pkg::REG_SEG_SECS:  seg_secs_q <= cfg_wdata_i[31:0];
        msbf_pkg::REG_TIMESCALE: tscale_q   <= cfg_wdata_i[31:0];
        msbf_pkg::REG_MIN_TAIL:  min_tail_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  logic [31:0] ts_eff, secs_eff;
  logic [39:0] tail_q;
  assign ts_eff   = (tscale_q == 32'd0) ? 32'd1 : tscale_q;
  assign secs_eff = (seg_secs_q == 32'd0) ? 32'd1 : seg_secs_q;

  // minimum tail in media units
  always_ff @(posedge clk_i) begin
    tail_q <= 40'(ts_eff) * 40'(min_tail_q);
  end

  // latched input fields
  logic [31:0] samples_q, delta_q, ss_q;

  // table state
  logic [RCW-1:0] rh_q;
  logic [SCW-1:0] sh_q;
  logic [31:0]    tot_samp_q;
  logic [63:0]    tot_time_q;
  logic           ovf_q;

  // walk registers
  logic [IW-1:0] idx_q;
  logic [31:0]   prev_end_q, prev_step_q;
  logic [63:0]   prev_start_q, base_q, t_q, tgt_q, best_q, dur_q, first_q, second_q;
  logic          any_q, ph_q;
  logic [MsW_L-1:0] sms_q, ems_q;
  localparam int unsigned MsW_L = msbf_pkg::MsW;

  // tables
  logic [31:0] run_end_mem   [RUN_ENTRIES];
  logic [63:0] run_start_mem [RUN_ENTRIES];
  logic [31:0] run_step_mem  [RUN_ENTRIES];
  logic [63:0] sync_mem      [SYNC_ENTRIES];
  logic [31:0] end_rd, step_rd;
  logic [63:0] start_rd, sync_rd;

  // shared arithmetic units
  logic         mul_start, div_start, mul_done, div_done;
  logic [63:0]  mul_a, mul_b, div_hi, div_lo, div_den, quot;
  logic [127:0] prod;

  msbf_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  msbf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .hi_i    (div_hi),
    .lo_i    (div_lo),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // derived values
  logic        found, use_sync;
  logic [63:0] cur_start, sat_sum, quot_sat;
  logic [64:0] tail_sum;
  logic [31:0] sync_off;
  logic        idx_at_rh;
  logic [MsW_L-1:0] ms_clamp;

  assign found     = (rh_q != '0);
  assign use_sync  = found && (sh_q != '0);
  assign idx_at_rh = (idx_q == IW'(rh_q));
  assign cur_start = idx_at_rh ? tot_time_q : start_rd;
  assign sync_off  = ss_q - (prev_end_q + 32'd1);
  assign tail_sum  = {1'b0, second_q} + 65'(tail_q);
  assign sat_sum   = tail_sum[64] ? msbf_pkg::ALL64 : tail_sum[63:0];
  assign quot_sat  = (prod[127:64] != 64'd0) ? msbf_pkg::ALL64 : prod[63:0];
  assign ms_clamp  = (quot > 64'(msbf_pkg::MAX45)) ? msbf_pkg::MAX45 : quot[MsW_L-1:0];

  // operand selection for the shared units
  always_comb begin
    mul_start = 1'b0;
    mul_a     = 64'd0;
    mul_b     = 64'd0;
    div_start = 1'b0;
    div_hi    = 64'd0;
    div_lo    = 64'd0;
    div_den   = 64'd1;
    case (cmd_i.act)
      msbf_pkg::A_RUN_WRITE: begin
        mul_start = 1'b1; mul_a = 64'(samples_q); mul_b = 64'(delta_q);
      end
      msbf_pkg::A_SY_MUL: begin
        mul_start = 1'b1; mul_a = 64'(sync_off); mul_b = 64'(step_rd);
      end
      msbf_pkg::A_DUR_MUL: begin
        mul_start = 1'b1; mul_a = 64'(secs_eff); mul_b = 64'(ts_eff);
      end
      msbf_pkg::A_DUR_SET: begin
        mul_start = 1'b1; mul_a = 64'(start_ms_q); mul_b = 64'(ts_eff);
      end
      msbf_pkg::A_G_MUL: begin
        mul_start = 1'b1; mul_a = quot; mul_b = 64'(prev_step_q);
      end
      msbf_pkg::A_NB_MUL: begin
        mul_start = 1'b1; mul_a = quot + 64'd1; mul_b = dur_q;
      end
      msbf_pkg::A_MS_MUL: begin
        mul_start = 1'b1; mul_a = ph_q ? second_q : first_q;
        mul_b = msbf_pkg::MS_PER_S;
      end
      msbf_pkg::A_TGT_DIV: begin
        div_start = 1'b1; div_hi = prod[127:64]; div_lo = prod[63:0];
        div_den = msbf_pkg::MS_PER_S;
      end
      msbf_pkg::A_G_DIV: begin
        div_start = 1'b1;
        div_lo  = t_q - prev_start_q + 64'(prev_step_q) - 64'd1;
        div_den = 64'(prev_step_q);
      end
      msbf_pkg::A_SRCH_FIRST: begin
        div_start = 1'b1; div_lo = use_sync ? best_q : tgt_q; div_den = dur_q;
      end
      msbf_pkg::A_MS_DIV: begin
        div_start = 1'b1; div_hi = prod[127:64]; div_lo = prod[63:0];
        div_den = 64'(ts_eff);
      end
      default: ;
    endcase
  end

  // table reads, registered
  always_ff @(posedge clk_i) begin
    end_rd   <= run_end_mem[idx_q[RAW-1:0]];
    start_rd <= run_start_mem[idx_q[RAW-1:0]];
    step_rd  <= run_step_mem[idx_q[RAW-1:0]];
    sync_rd  <= sync_mem[idx_q[SAW-1:0]];
  end

  // table writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.act == msbf_pkg::A_RUN_WRITE) begin
      run_end_mem[rh_q[RAW-1:0]]   <= tot_samp_q + samples_q;
      run_start_mem[rh_q[RAW-1:0]] <= tot_time_q;
      run_step_mem[rh_q[RAW-1:0]]  <= delta_q;
    end
    if (cmd_i.act == msbf_pkg::A_SY_WRITE) begin
      sync_mem[sh_q[SAW-1:0]] <= t_q;
    end
  end

  // control state of the tables and the result register
  logic        out_valid_q;
  logic [95:0] out_data_q;
  logic [2:0]  out_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rh_q        <= '0;
      sh_q        <= '0;
      tot_samp_q  <= 32'd0;
      tot_time_q  <= 64'd0;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      ph_q        <= 1'b0;
      any_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.act)
        msbf_pkg::A_ACCEPT: begin
          idx_q <= '0; ph_q <= 1'b0; any_q <= 1'b0;
        end
        msbf_pkg::A_RUN_WRITE: begin
          rh_q       <= rh_q + RCW'(1);
          tot_samp_q <= tot_samp_q + samples_q;
        end
        msbf_pkg::A_RUN_DROP:  ovf_q <= 1'b1;
        msbf_pkg::A_RUN_ADD:   tot_time_q <= tot_time_q + prod[63:0];
        msbf_pkg::A_SY_NEXT:   idx_q <= idx_q + IW'(1);
        msbf_pkg::A_SY_WRITE:  sh_q <= sh_q + SCW'(1);
        msbf_pkg::A_SY_DROP:   ovf_q <= 1'b1;
        msbf_pkg::A_SS_CHK: begin
          idx_q <= idx_q + IW'(1);
          if (sync_rd >= t_q && (!any_q || sync_rd < best_q)) begin
            any_q <= 1'b1;
          end
        end
        msbf_pkg::A_G_PREV:    idx_q <= idx_q + IW'(1);
        msbf_pkg::A_NB_SET: begin
          idx_q <= '0; ph_q <= 1'b1; any_q <= 1'b0;
        end
        msbf_pkg::A_TAIL:      ph_q <= 1'b0;
        msbf_pkg::A_MS_SET:    ph_q <= 1'b1;
        msbf_pkg::A_FIN: begin
          out_valid_q <= 1'b1;
          rh_q        <= '0;
          sh_q        <= '0;
          tot_samp_q  <= 32'd0;
          tot_time_q  <= 64'd0;
          ovf_q       <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // payload registers of the walk
  always_ff @(posedge clk_i) begin
    case (cmd_i.act)
      msbf_pkg::A_ACCEPT: begin
        samples_q  <= in_data_i[31:0];
        delta_q    <= in_data_i[63:32];
        ss_q       <= in_data_i[95:64];
        prev_end_q <= 32'd0;
        t_q        <= tot_time_q;
        best_q     <= tot_time_q;
      end
      msbf_pkg::A_SY_NEXT:   prev_end_q <= end_rd;
      msbf_pkg::A_SY_MUL:    base_q <= start_rd;
      msbf_pkg::A_SY_SUM:    t_q <= base_q + prod[63:0];
      msbf_pkg::A_DUR_SET:   dur_q <= prod[63:0];
      msbf_pkg::A_TGT_SET: begin
        t_q   <= quot;
        tgt_q <= quot;
      end
      msbf_pkg::A_SS_CHK: begin
        if (sync_rd >= t_q && (!any_q || sync_rd < best_q)) begin
          best_q <= sync_rd;
        end
      end
      msbf_pkg::A_G_PREV: begin
        prev_start_q <= cur_start;
        prev_step_q  <= step_rd;
      end
      msbf_pkg::A_G_BASE:    best_q <= prev_start_q;
      msbf_pkg::A_G_SUM:     best_q <= prev_start_q + prod[63:0];
      msbf_pkg::A_G_END_TOT: best_q <= tot_time_q;
      msbf_pkg::A_SRCH_FIRST: first_q <= best_q;
      msbf_pkg::A_NB_SET: begin
        t_q    <= quot_sat;
        best_q <= tot_time_q;
      end
      msbf_pkg::A_SRCH_SECOND: second_q <= best_q;
      msbf_pkg::A_TAIL: begin
        if (second_q != tot_time_q && tot_time_q < sat_sum) begin
          second_q <= tot_time_q;
        end
      end
      msbf_pkg::A_MS_SET: begin
        if (ph_q) begin
          ems_q <= ms_clamp;
        end else begin
          sms_q <= ms_clamp;
        end
      end
      msbf_pkg::A_FIN: begin
        out_data_q <= {6'd0, found ? ems_q : '0, found ? sms_q : '0};
        out_user_q <= {ovf_q, use_sync, found};
      end
      default: ;
    endcase
  end

  // status toward the controller
  always_comb begin
    status_o.in_valid  = in_valid_i;
    status_o.in_op     = in_op_i;
    status_o.samp_zero = (samples_q == 32'd0);
    status_o.run_full  = (rh_q == RCW'(RUN_ENTRIES));
    status_o.sync_full = (sh_q == SCW'(SYNC_ENTRIES));
    status_o.idx_at_rh = idx_at_rh;
    status_o.idx_at_sh = (idx_q == IW'(sh_q));
    status_o.idx_zero  = (idx_q == '0);
    status_o.end_ge_ss = (end_rd >= ss_q);
    status_o.grid_skip = (cur_start == prev_start_q) || (prev_step_q == 32'd0);
    status_o.grid_hit  = (cur_start > t_q);
    status_o.t_gt_st   = (t_q > prev_start_q);
    status_o.found     = found;
    status_o.use_sync  = use_sync;
    status_o.ph        = ph_q;
    status_o.mul_done  = mul_done;
    status_o.div_done  = div_done;
    status_o.out_busy  = out_valid_q && !out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

endmodule

`default_nettype wire

FILE: design/msbf_ctrl.sv
// ----------------------------------------------------------------------------
// msbf_ctrl
// Controller: sequences loads, table walks and the boundary computation.
// ----------------------------------------------------------------------------
`default_nettype none

module msbf_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire msbf_pkg::status_t status_i,
  output msbf_pkg::cmd_t         cmd_o
);

  msbf_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= msbf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      msbf_pkg::ST_IDLE: begin
        if (status_i.in_valid) begin
          case (status_i.in_op)
            msbf_pkg::OP_LOAD_RUN:  state_d = msbf_pkg::ST_RUN_CHK;
            msbf_pkg::OP_LOAD_SYNC: state_d = msbf_pkg::ST_SY_RD;
            msbf_pkg::OP_COMPUTE:   state_d = msbf_pkg::ST_CP_DUR;
            default:                state_d = msbf_pkg::ST_IDLE;
          endcase
        end
      end
      msbf_pkg::ST_RUN_CHK: begin
        if (status_i.samp_zero || status_i.run_full) state_d = msbf_pkg::ST_IDLE;
        else state_d = msbf_pkg::ST_RUN_MUL;
      end
      msbf_pkg::ST_RUN_MUL: if (status_i.mul_done) state_d = msbf_pkg::ST_IDLE;
      msbf_pkg::ST_SY_RD: begin
        state_d = status_i.idx_at_rh ? msbf_pkg::ST_SY_STORE : msbf_pkg::ST_SY_CHK;
      end
      msbf_pkg::ST_SY_CHK: begin
        state_d = status_i.end_ge_ss ? msbf_pkg::ST_SY_MULW : msbf_pkg::ST_SY_RD;
      end
      msbf_pkg::ST_SY_MULW: if (status_i.mul_done) state_d = msbf_pkg::ST_SY_STORE;
      msbf_pkg::ST_SY_STORE: state_d = msbf_pkg::ST_IDLE;
      msbf_pkg::ST_CP_DUR:   state_d = msbf_pkg::ST_CP_DURW;
      msbf_pkg::ST_CP_DURW:  if (status_i.mul_done) state_d = msbf_pkg::ST_CP_TGTM;
      msbf_pkg::ST_CP_TGTM:  if (status_i.mul_done) state_d = msbf_pkg::ST_CP_TGTD;
      msbf_pkg::ST_CP_TGTD: begin
        if (status_i.div_done) begin
          if (!status_i.found) state_d = msbf_pkg::ST_FIN;
          else if (status_i.use_sync) state_d = msbf_pkg::ST_SS_RD;
          else state_d = msbf_pkg::ST_G_RD;
        end
      end
      msbf_pkg::ST_SS_RD: begin
        state_d = status_i.idx_at_sh ? msbf_pkg::ST_S_END : msbf_pkg::ST_SS_CHK;
      end
      msbf_pkg::ST_SS_CHK: state_d = msbf_pkg::ST_SS_RD;
      msbf_pkg::ST_G_RD:   state_d = msbf_pkg::ST_G_CHK;
      msbf_pkg::ST_G_CHK: begin
        if (status_i.idx_zero) state_d = msbf_pkg::ST_G_RD;
        else if (!status_i.grid_skip && status_i.grid_hit) begin
          state_d = status_i.t_gt_st ? msbf_pkg::ST_G_DIVW : msbf_pkg::ST_S_END;
        end else if (status_i.idx_at_rh) state_d = msbf_pkg::ST_S_END;
        else state_d = msbf_pkg::ST_G_RD;
      end
      msbf_pkg::ST_G_DIVW: if (status_i.div_done) state_d = msbf_pkg::ST_G_MULW;
      msbf_pkg::ST_G_MULW: if (status_i.mul_done) state_d = msbf_pkg::ST_S_END;
      msbf_pkg::ST_S_END: begin
        state_d = status_i.ph ? msbf_pkg::ST_TAIL : msbf_pkg::ST_NB_DIV;
      end
      msbf_pkg::ST_NB_DIV: if (status_i.div_done) state_d = msbf_pkg::ST_NB_MULW;
      msbf_pkg::ST_NB_MULW: begin
        if (status_i.mul_done) begin
          state_d = status_i.use_sync ? msbf_pkg::ST_SS_RD : msbf_pkg::ST_G_RD;
        end
      end
      msbf_pkg::ST_TAIL:    state_d = msbf_pkg::ST_MS_MUL;
      msbf_pkg::ST_MS_MUL:  state_d = msbf_pkg::ST_MS_MULW;
      msbf_pkg::ST_MS_MULW: if (status_i.mul_done) state_d = msbf_pkg::ST_MS_DIVW;
      msbf_pkg::ST_MS_DIVW: begin
        if (status_i.div_done) begin
          state_d = status_i.ph ? msbf_pkg::ST_FIN : msbf_pkg::ST_MS_MUL;
        end
      end
      msbf_pkg::ST_FIN: if (!status_i.out_busy) state_d = msbf_pkg::ST_IDLE;
      default: state_d = msbf_pkg::ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o.act      = msbf_pkg::A_NONE;
    cmd_o.in_ready = 1'b0;
    case (state_q)
      msbf_pkg::ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (status_i.in_valid) cmd_o.act = msbf_pkg::A_ACCEPT;
      end
      msbf_pkg::ST_RUN_CHK: begin
        if (status_i.samp_zero) cmd_o.act = msbf_pkg::A_NONE;
        else if (status_i.run_full) cmd_o.act = msbf_pkg::A_RUN_DROP;
        else cmd_o.act = msbf_pkg::A_RUN_WRITE;
      end
      msbf_pkg::ST_RUN_MUL: if (status_i.mul_done) cmd_o.act = msbf_pkg::A_RUN_ADD;
      msbf_pkg::ST_SY_CHK: begin
        cmd_o.act = status_i.end_ge_ss ? msbf_pkg::A_SY_MUL : msbf_pkg::A_SY_NEXT;
      end
      msbf_pkg::ST_SY_MULW: if (status_i.mul_done) cmd_o.act = msbf_pkg::A_SY_SUM;
      msbf_pkg::ST_SY_STORE: begin
        cmd_o.act = status_i.sync_full ? msbf_pkg::A_SY_DROP : msbf_pkg::A_SY_WRITE;
      end
      msbf_pkg::ST_CP_DUR:  cmd_o.act = msbf_pkg::A_DUR_MUL;
      msbf_pkg::ST_CP_DURW: if (status_i.mul_done) cmd_o.act = msbf_pkg::A_DUR_SET;
      msbf_pkg::ST_CP_TGTM: if (status_i.mul_done) cmd_o.act = msbf_pkg::A_TGT_DIV;
      msbf_pkg::ST_CP_TGTD: if (status_i.div_done) cmd_o.act = msbf_pkg::A_TGT_SET;
      msbf_pkg::ST_SS_CHK:  cmd_o.act = msbf_pkg::A_SS_CHK;
      msbf_pkg::ST_G_CHK: begin
        if (status_i.idx_zero) cmd_o.act = msbf_pkg::A_G_PREV;
        else if (!status_i.grid_skip && status_i.grid_hit) begin
          cmd_o.act = status_i.t_gt_st ? msbf_pkg::A_G_DIV : msbf_pkg::A_G_BASE;
        end else if (status_i.idx_at_rh) cmd_o.act = msbf_pkg::A_G_END_TOT;
        else cmd_o.act = msbf_pkg::A_G_PREV;
      end
      msbf_pkg::ST_G_DIVW: if (status_i.div_done) cmd_o.act = msbf_pkg::A_G_MUL;
      msbf_pkg::ST_G_MULW: if (status_i.mul_done) cmd_o.act = msbf_pkg::A_G_SUM;
      msbf_pkg::ST_S_END: begin
        cmd_o.act = status_i.ph ? msbf_pkg::A_SRCH_SECOND : msbf_pkg::A_SRCH_FIRST;
      end
      msbf_pkg::ST_NB_DIV:  if (status_i.div_done) cmd_o.act = msbf_pkg::A_NB_MUL;
      msbf_pkg::ST_NB_MULW: if (status_i.mul_done) cmd_o.act = msbf_pkg::A_NB_SET;
      msbf_pkg::ST_TAIL:    cmd_o.act = msbf_pkg::A_TAIL;
      msbf_pkg::ST_MS_MUL:  cmd_o.act = msbf_pkg::A_MS_MUL;
      msbf_pkg::ST_MS_MULW: if (status_i.mul_done) cmd_o.act = msbf_pkg::A_MS_DIV;
      msbf_pkg::ST_MS_DIVW: if (status_i.div_done) cmd_o.act = msbf_pkg::A_MS_SET;
      msbf_pkg::ST_FIN:     if (!status_i.out_busy) cmd_o.act = msbf_pkg::A_FIN;
      default: cmd_o.act = msbf_pkg::A_NONE;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/media_segment_boundary_finder.sv
// ----------------------------------------------------------------------------
// media_segment_boundary_finder
// Loads time-to-sample runs and sync samples of one track and computes one
// segment's start and end in milliseconds.
//
//   channel  direction  transfer carries
//   s_axis   in         one load or compute command
//   m_axis   out        one segment result, after a compute command only
//   cfg      in         one register write, taken every cycle
//
// One item at a time. A run load uses the 32x32 multiplier four times. A
// sync load scans the held runs and then multiplies at most once. A compute
// takes several passes of the bit-serial divider and two walks over the
// held table entries. Reset clears the counts; the tables need no clearing
// pass. A finished result waits in the output register, while loads
// continue; the next compute holds at its end until that is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module media_segment_boundary_finder #(
  parameter int unsigned RUN_ENTRIES  = 256,
  parameter int unsigned SYNC_ENTRIES = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [39:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [95:0] s_axis_tdata,  // run_samples, run_delta, sync_sample
  input  wire logic [1:0]  s_axis_tuser,  // opcode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [95:0]      m_axis_tdata,  // seg_start_ms, seg_end_ms, zero fill
  output logic [2:0]       m_axis_tuser   // found, used_sync, table_overflow
);

  msbf_pkg::cmd_t    cmd;
  msbf_pkg::status_t status;

  msbf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  msbf_dp #(
    .RUN_ENTRIES  (RUN_ENTRIES),
    .SYNC_ENTRIES (SYNC_ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_op_i     (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

  assign s_axis_tready = cmd.in_ready;

endmodule

`default_nettype wire

FILE: bench/tb_media_segment_boundary_finder.sv
// ----------------------------------------------------------------------------
// tb_media_segment_boundary_finder
// Self-checking bench for the segment boundary finder. A directed table and
// random load/compute sequences drive the command stream. Each compute is
// predicted by a behavioral track model (or given in the directed table) and checked field by field against
// the result stream, under random idling, a long receiver hold-off and a
// table overflow pass.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_media_segment_boundary_finder;
  import msbf_pkg::*;

  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam int unsigned TRACK_ENTRIES = 256;
  localparam int unsigned DRAIN_CYCLES = 1200;
  localparam int unsigned CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [44:0] start_ms;
    logic [44:0] end_ms;
    logic        found;
    logic        used_sync;
    logic        overflow;
  } segment_t;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] samples;
    logic [31:0] delta;
    logic [31:0] sync_num;
    bit          typed;
    logic [44:0] start_ms;
    logic [44:0] end_ms;
    logic [2:0]  flags;  // found, used_sync, table_overflow
  } cmd_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [39:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  media_segment_boundary_finder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // track model state
  logic [39:0] req_start_ms;
  logic [31:0] seg_secs;
  logic [31:0] timescale;
  logic [7:0]  min_tail;
  logic [31:0] run_end_cnt [TRACK_ENTRIES];
  logic [63:0] run_t0 [TRACK_ENTRIES];
  logic [31:0] run_dt [TRACK_ENTRIES];
  logic [63:0] sync_t [TRACK_ENTRIES];
  int unsigned n_runs;
  int unsigned n_syncs;
  logic [31:0] sum_samples;
  logic [63:0] sum_time;
  logic        dropped;

  segment_t    expected_segments [$];
  int unsigned errors = 0;
  int unsigned snd_idle = 0;
  int unsigned rcv_idle = 0;
  bit          hold_go = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;

  // exact floor(a*b/c), saturated to 64 bits
  function automatic logic [63:0] mul_div_sat(logic [63:0] a, logic [63:0] b, logic [63:0] c);
    logic [127:0] q;
    q = ({64'd0, a} * {64'd0, b}) / {64'd0, c};
    return (q[127:64] != 0) ? ALL64 : q[63:0];
  endfunction

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
    return (a > ALL64 - b) ? ALL64 : a + b;
  endfunction

  // next multiple of d strictly above t
  function automatic logic [63:0] boundary_after(logic [63:0] t, logic [63:0] d);
    logic [63:0] q;
    q = t / d + 64'd1;
    return (q > ALL64 / d) ? ALL64 : q * d;
  endfunction

  function automatic logic [63:0] sync_at_or_after(logic [63:0] t);
    logic [63:0] best;
    bit          any;
    best = sum_time;
    any = 1'b0;
    for (int unsigned i = 0; i < n_syncs; i++) begin
      if (sync_t[i] >= t && (!any || sync_t[i] < best)) begin
        best = sync_t[i];
        any = 1'b1;
      end
    end
    return best;
  endfunction

  function automatic logic [63:0] grid_at_or_after(logic [63:0] t);
    logic [63:0] st, en, d, sc;
    for (int unsigned i = 0; i < n_runs; i++) begin
      st = run_t0[i];
      en = (i + 1 < n_runs) ? run_t0[i+1] : sum_time;
      d = {32'd0, run_dt[i]};
      if (en != st && d != 0 && en > t) begin
        sc = (t > st) ? (t - st + d - 64'd1) / d : 64'd0;
        return st + sc * d;
      end
    end
    return sum_time;
  endfunction

  // apply one accepted command to the track model
  task automatic track_step(input logic [1:0] op, input logic [31:0] samples,
                            input logic [31:0] delta, input logic [31:0] sync_num,
                            output bit has_seg, output segment_t seg);
    logic [63:0] t, ts, secs, dur, target, first, second, s_ms, e_ms;
    logic [31:0] first_num;
    bit          hit;
    has_seg = 1'b0;
    seg = '0;
    case (op)
      OP_LOAD_RUN: begin
        if (samples != 0) begin
          if (n_runs >= TRACK_ENTRIES) begin
            dropped = 1'b1;
          end else begin
            run_end_cnt[n_runs] = sum_samples + samples;
            run_t0[n_runs] = sum_time;
            run_dt[n_runs] = delta;
            n_runs++;
            sum_samples += samples;
            sum_time += {32'd0, samples} * {32'd0, delta};
          end
        end
      end
      OP_LOAD_SYNC: begin
        t = sum_time;
        hit = 1'b0;
        for (int unsigned i = 0; i < n_runs && !hit; i++) begin
          if (run_end_cnt[i] >= sync_num) begin
            first_num = (i == 0 ? 32'd0 : run_end_cnt[i-1]) + 32'd1;
            t = run_t0[i] + {32'd0, sync_num - first_num} * {32'd0, run_dt[i]};
            hit = 1'b1;
          end
        end
        if (n_syncs >= TRACK_ENTRIES) dropped = 1'b1;
        else sync_t[n_syncs++] = t;
      end
      OP_COMPUTE: begin
        ts = (timescale != 0) ? {32'd0, timescale} : 64'd1;
        secs = (seg_secs != 0) ? {32'd0, seg_secs} : 64'd1;
        dur = secs * ts;
        seg.found = (n_runs > 0);
        seg.used_sync = seg.found && (n_syncs > 0);
        seg.overflow = dropped;
        if (seg.found) begin
          target = mul_div_sat({24'd0, req_start_ms}, ts, MS_PER_S);
          if (seg.used_sync) begin
            first = sync_at_or_after(target);
            second = sync_at_or_after(boundary_after(first, dur));
          end else begin
            first = grid_at_or_after(target);
            second = grid_at_or_after(boundary_after(target, dur));
          end
          // short remainder snaps to track end
          if (second != sum_time && sum_time < add_sat(second, ts * {56'd0, min_tail}))
            second = sum_time;
          s_ms = mul_div_sat(first, MS_PER_S, ts);
          e_ms = mul_div_sat(second, MS_PER_S, ts);
          seg.start_ms = (s_ms > {19'd0, MAX45}) ? MAX45 : s_ms[44:0];
          seg.end_ms = (e_ms > {19'd0, MAX45}) ? MAX45 : e_ms[44:0];
        end
        n_runs = 0;
        n_syncs = 0;
        sum_samples = 0;
        sum_time = 0;
        dropped = 1'b0;
        has_seg = 1'b1;
      end
      default: ;
    endcase
  endtask

  // offer one command, wait for its transfer, then predict
  task automatic send_cmd(input logic [1:0] op, input logic [31:0] samples,
                          input logic [31:0] delta, input logic [31:0] sync_num,
                          input bit typed, input segment_t typed_seg);
    bit       has_seg;
    segment_t seg;
    if ($urandom_range(99) < snd_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < snd_idle) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {sync_num, delta, samples};
    do @(posedge clk_i); while (!s_axis_tready);
    track_step(op, samples, delta, sync_num, has_seg, seg);
    if (has_seg) expected_segments.push_back(typed ? typed_seg : seg);
  endtask

  task automatic send(input logic [1:0] op, input logic [31:0] samples,
                      input logic [31:0] delta, input logic [31:0] sync_num);
    send_cmd(op, samples, delta, sync_num, 1'b0, '0);
  endtask

  // stop offering and let every result and trailing load finish
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_segments.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] addr, input logic [39:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= val;
    @(posedge clk_i);
    case (addr)
      REG_START_MS:  req_start_ms = val;
      REG_SEG_SECS:  seg_secs = val[31:0];
      REG_TIMESCALE: timescale = val[31:0];
      default:       min_tail = val[7:0];
    endcase
  endtask

  task automatic set_config(input logic [39:0] start_ms, input logic [31:0] secs,
                            input logic [31:0] ts, input logic [7:0] tail);
    drain();
    cfg_write(REG_START_MS, start_ms);
    cfg_write(REG_SEG_SECS, {8'd0, secs});
    cfg_write(REG_TIMESCALE, {8'd0, ts});
    cfg_write(REG_MIN_TAIL, {32'd0, tail});
    cfg_we <= 1'b0;
  endtask

  // mostly well-formed track loads followed by a compute, some noise
  task automatic random_items(input int unsigned count);
    int unsigned sent, n_r, n_s;
    logic [31:0] dt_base;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 15) begin
        case ($urandom_range(4))
          0: send(OP_RESERVED, $urandom, $urandom, $urandom);
          1: send(OP_LOAD_RUN, 32'd0, $urandom, $urandom);
          2: send(OP_LOAD_RUN, $urandom, $urandom, $urandom);
          3: send(OP_LOAD_SYNC, $urandom, $urandom, $urandom);
          default: send(OP_COMPUTE, $urandom, $urandom, $urandom);
        endcase
        sent++;
      end else begin
        n_r = $urandom_range(1, 6);
        n_s = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 5);
        dt_base = (timescale / 25) + 1;
        for (int unsigned i = 0; i < n_r; i++) begin
          send(OP_LOAD_RUN, $urandom_range(1, 400),
               ($urandom_range(7) == 0) ? 32'd0 : $urandom_range(1, 2 * dt_base), $urandom);
        end
        for (int unsigned i = 0; i < n_s; i++) begin
          send(OP_LOAD_SYNC, $urandom, $urandom,
               ($urandom_range(9) == 0) ? 32'd0 : $urandom_range(1, sum_samples + 3));
        end
        if ($urandom_range(9) != 0) send(OP_COMPUTE, $urandom, $urandom, $urandom);
        sent += n_r + n_s + 1;
      end
    end
  endtask

  // directed commands, defaults after reset apply
  cmd_row_t cmd_tab [0:19] = '{
    '{OP_COMPUTE,   32'd0, 32'd0, 32'd0, 1'b1, 45'd0, 45'd0, 3'b000},  // after reset
    '{OP_RESERVED,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 45'd0, 45'd0, 3'b000},
    '{OP_LOAD_RUN,  32'd0, 32'd7, 32'd0, 1'b0, 45'd0, 45'd0, 3'b000},  // empty run
    '{OP_COMPUTE,   32'd0, 32'd0, 32'd0, 1'b1, 45'd0, 45'd0, 3'b000},  // no runs held
    '{OP_LOAD_RUN,  32'd100, 32'd10, 32'd0, 1'b0, 45'd0, 45'd0, 3'b000},
    '{OP_COMPUTE,   32'd0, 32'd0, 32'd0, 1'b1, 45'd0, 45'd1000, 3'b001},
    '{OP_LOAD_SYNC, 32'd0, 32'd0, 32'd5, 1'b0, 45'd0, 45'd0, 3'b000},  // sync before runs
    '{OP_LOAD_RUN,  32'd50, 32'd40, 32'd0, 1'b0, 45'd0, 45'd0, 3'b000},
    '{OP_LOAD_RUN,  32'd10, 32'd0, 32'd0, 1'b0, 45'd0, 45'd0, 3'b000},  // zero duration
    '{OP_LOAD_RUN,  32'd200, 32'd40, 32'd0, 1'b0, 45'd0, 45'd0, 3'b000},
    '{OP_LOAD_SYNC, 32'd0, 32'd0, 32'd0, 1'b0, 45'd0, 45'd0, 3'b000},  // sync number zero
    '{OP_LOAD_SYNC, 32'd0, 32'd0, 32'd60, 1'b0, 45'd0, 45'd0, 3'b000},
    '{OP_LOAD_SYNC, 32'd0, 32'd0, 32'd300, 1'b0, 45'd0, 45'd0, 3'b000},  // past last run
    '{OP_COMPUTE,   32'd0, 32'd0, 32'd0, 1'b0, 45'd0, 45'd0, 3'b000},
    '{OP_LOAD_RUN,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b0, 45'd0, 45'd0, 3'b000},
    '{OP_LOAD_RUN,  32'd1, 32'd1, 32'd0, 1'b0, 45'd0, 45'd0, 3'b000},
    '{OP_LOAD_SYNC, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0, 45'd0, 45'd0, 3'b000},
    '{OP_COMPUTE,   32'd0, 32'd0, 32'd0, 1'b0, 45'd0, 45'd0, 3'b000},
    '{OP_LOAD_SYNC, 32'd0, 32'd0, 32'd1, 1'b0, 45'd0, 45'd0, 3'b000},
    '{OP_COMPUTE,   32'd0, 32'd0, 32'd0, 1'b1, 45'd0, 45'd0, 3'b000}   // syncs only
  };

  // result side: random stall, long hold-off, check each transfer
  always @(posedge clk_i) begin
    segment_t want;
    if (hold_go) hold_left <= 4000;
    else if (hold_left != 0) hold_left <= hold_left - 1;
    m_axis_tready <= (hold_go || hold_left > 1) ? 1'b0 : ($urandom_range(99) >= rcv_idle);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_segments.size() == 0) begin
        $display("%0t: unexpected segment start %0d end %0d flags %b", $time,
                 m_axis_tdata[44:0], m_axis_tdata[89:45], m_axis_tuser);
        errors++;
      end else begin
        want = expected_segments.pop_front();
        if (m_axis_tdata[44:0] !== want.start_ms) begin
          $display("%0t: seg_start_ms expected %0d actual %0d", $time, want.start_ms,
                   m_axis_tdata[44:0]);
          errors++;
        end
        if (m_axis_tdata[89:45] !== want.end_ms) begin
          $display("%0t: seg_end_ms expected %0d actual %0d", $time, want.end_ms,
                   m_axis_tdata[89:45]);
          errors++;
        end
        if (m_axis_tuser[0] !== want.found) begin
          $display("%0t: found expected %b actual %b", $time, want.found, m_axis_tuser[0]);
          errors++;
        end
        if (m_axis_tuser[1] !== want.used_sync) begin
          $display("%0t: used_sync expected %b actual %b", $time, want.used_sync,
                   m_axis_tuser[1]);
          errors++;
        end
        if (m_axis_tuser[2] !== want.overflow) begin
          $display("%0t: table_overflow expected %b actual %b", $time, want.overflow,
                   m_axis_tuser[2]);
          errors++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // main sequence
  initial begin
    req_start_ms = 0;
    seg_secs = 10;
    timescale = 1000;
    min_tail = 1;
    n_runs = 0;
    n_syncs = 0;
    sum_samples = 0;
    sum_time = 0;
    dropped = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    snd_idle = 16;
    rcv_idle = 54;
    foreach (cmd_tab[i]) begin
      send_cmd(cmd_tab[i].op, cmd_tab[i].samples, cmd_tab[i].delta, cmd_tab[i].sync_num,
               cmd_tab[i].typed, '{cmd_tab[i].start_ms, cmd_tab[i].end_ms,
               cmd_tab[i].flags[0], cmd_tab[i].flags[1], cmd_tab[i].flags[2]});
    end

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        snd_idle = 54;
        rcv_idle = 16;
      end else if (ph == 4) begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      case (ph)
        0: set_config(40'd0, 32'd0, 32'd0, 8'd0);  // zero length and timescale act as one
        1: set_config({40{1'b1}}, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        default: begin
          case ($urandom_range(4))
            0: set_config($urandom_range(0, 20000), $urandom_range(1, 12), 32'd90000,
                          $urandom_range(0, 3));
            1: set_config($urandom_range(0, 20000), $urandom_range(1, 12), 32'd48000,
                          $urandom_range(0, 3));
            2: set_config($urandom_range(0, 20000), $urandom_range(1, 12), 32'd600,
                          $urandom_range(0, 3));
            3: set_config($urandom_range(0, 20000), $urandom_range(1, 12),
                          $urandom_range(1, 100000), $urandom_range(0, 3));
            default: set_config($urandom_range(0, 20000), $urandom_range(1, 12), 32'd1000,
                                $urandom_range(0, 3));
          endcase
        end
      endcase
      random_items(90);
    end

    // receiver holds off while computes pile up behind the output register
    drain();
    hold_go <= 1'b1;
    @(posedge clk_i);
    hold_go <= 1'b0;
    for (int i = 0; i < 4; i++) begin
      send(OP_LOAD_RUN, $urandom_range(1, 300), $urandom_range(1, 60), 32'd0);
      send(OP_LOAD_SYNC, 32'd0, 32'd0, $urandom_range(1, 300));
      send(OP_COMPUTE, 32'd0, 32'd0, 32'd0);
    end
    drain();

    // fill both tables past capacity
    for (int i = 0; i < TRACK_ENTRIES + 2; i++)
      send(OP_LOAD_RUN, $urandom_range(1, 3), $urandom_range(0, 50), 32'd0);
    for (int i = 0; i < TRACK_ENTRIES + 2; i++)
      send(OP_LOAD_SYNC, 32'd0, 32'd0, $urandom_range(1, 5));
    send(OP_COMPUTE, 32'd0, 32'd0, 32'd0);
    send(OP_LOAD_RUN, 32'd5, 32'd20, 32'd0);
    send(OP_COMPUTE, 32'd0, 32'd0, 32'd0);

    drain();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
design/msbf_pkg.sv
design/msbf_mul.sv
design/msbf_div.sv
design/msbf_dp.sv
design/msbf_ctrl.sv
design/media_segment_boundary_finder.sv
bench/tb_media_segment_boundary_finder.sv
